>>> sv/sbus_pkg.sv
`timescale 1ns / 1ps

package sbus_pkg;

  localparam int FrameLen    = 25;
  localparam int PosWidth    = 5;
  localparam int NumChannels = 16;
  localparam int ChanWidth   = 4;
  localparam int RawWidth    = 11;
  localparam int ByteWidth   = 8;
  // channel data sits in bytes 1 to 22
  localparam int DataBytes   = 22;
  localparam int DataBits    = DataBytes * ByteWidth;
  // bytes held in the collection shift line before the last byte arrives
  localparam int HeldBytes   = FrameLen - 1;

  localparam int NumWidth    = 4;
  localparam int OffWidth    = 12;
  localparam int ValueWidth  = 13;
  localparam int CountWidth  = 16;
  localparam int ProdWidth   = RawWidth + NumWidth;

  localparam int CfgIndexWidth = 8;
  localparam int CfgDataWidth  = 12;

  localparam int QueueDepth  = 2;

  localparam logic [ByteWidth-1:0] HeaderByte = 8'h0f;
  localparam logic [ByteWidth-1:0] EndByte    = 8'h00;

  localparam logic [PosWidth-1:0]  LastPos    = PosWidth'(FrameLen - 1);
  localparam logic [ChanWidth-1:0] LastChan   = ChanWidth'(NumChannels - 1);

  localparam logic [NumWidth-1:0]  NumReset   = 4'd5;
  localparam logic [OffWidth-1:0]  OffReset   = 12'd874;

  localparam logic [CfgIndexWidth-1:0] RegScaleNum  = 8'd0;
  localparam logic [CfgIndexWidth-1:0] RegOutOffset = 8'd1;

  typedef struct packed {
    logic                  ok;
    logic [CountWidth-1:0] bad_count;
    logic [DataBits-1:0]   data;
  } frame_t;

endpackage

>>> sv/sbus_front.sv
`timescale 1ns / 1ps

module sbus_front import sbus_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ByteWidth-1:0] rx_byte,
  input  logic                 q_full,
  output logic                 q_push,
  output frame_t               q_entry
);

  logic [PosWidth-1:0]             pos;
  logic [CountWidth-1:0]           bad_count;
  logic [CountWidth-1:0]           bad_count_next;
  logic [HeldBytes*ByteWidth-1:0]  held;
  logic                            accept;
  logic                            last_byte;
  logic                            good;

  assign last_byte = (pos == LastPos);
  // only the closing byte of a frame needs room in the queue
  assign in_stall  = last_byte && q_full;
  assign accept    = in_valid && !in_stall;
  assign q_push    = accept && last_byte;

  // byte k of the frame sits at held[8k +: 8] once 24 words are in
  assign good = (held[ByteWidth-1:0] == HeaderByte) && (rx_byte == EndByte);

  always_comb begin
    bad_count_next = bad_count;
    if (!good && (bad_count != {CountWidth{1'b1}})) begin
      bad_count_next = bad_count + 1'b1;
    end
  end

  assign q_entry.ok        = good;
  assign q_entry.bad_count = bad_count_next;
  assign q_entry.data      = held[ByteWidth +: DataBits];

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      bad_count <= '0;
    end else if (accept) begin
      if (last_byte) begin
        pos       <= '0;
        bad_count <= bad_count_next;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      held <= {rx_byte, held[HeldBytes*ByteWidth-1:ByteWidth]};
    end
  end

endmodule

>>> sv/sbus_queue.sv
`timescale 1ns / 1ps

module sbus_queue import sbus_pkg::*; #(
  parameter int DEPTH = QueueDepth
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  frame_t push_entry,
  output logic   full,
  input  logic   pop,
  output frame_t pop_entry,
  output logic   not_empty
);

  localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntWidth = $clog2(DEPTH + 1);
  localparam logic [PtrWidth-1:0] LastSlot = PtrWidth'(DEPTH - 1);
  localparam logic [CntWidth-1:0] FullCnt  = CntWidth'(DEPTH);

  frame_t                slots [DEPTH];
  logic [PtrWidth-1:0]   wr_ptr;
  logic [PtrWidth-1:0]   rd_ptr;
  logic [CntWidth-1:0]   fill;

  assign full      = (fill == FullCnt);
  assign not_empty = (fill != '0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastSlot) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastSlot) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("frame pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> not_empty)
    else $error("frame popped from an empty queue");
  a_fill_range: assert property (@(posedge clk) disable iff (rst) fill <= FullCnt)
    else $error("queue fill count out of range");

endmodule

>>> sv/sbus_back.sv
`timescale 1ns / 1ps

module sbus_back import sbus_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_not_empty,
  input  frame_t                q_entry,
  output logic                  q_pop,
  input  logic [NumWidth-1:0]   scale_numerator,
  input  logic [OffWidth-1:0]   output_offset,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  frame_ok,
  output logic [ChanWidth-1:0]  channel_index,
  output logic [RawWidth-1:0]   raw_value,
  output logic [ValueWidth-1:0] channel_value,
  output logic [CountWidth-1:0] bad_frames,
  output logic                  last_of_frame
);

  logic                   busy;
  logic                   ok;
  logic [CountWidth-1:0]  cnt;
  logic [DataBits-1:0]    data;
  logic [ChanWidth-1:0]   chan;
  logic                   adv;
  logic                   last_item;
  logic                   load;
  logic [RawWidth-1:0]    raw;
  logic [ProdWidth-1:0]   prod;
  logic [ValueWidth-1:0]  scaled_value;

  assign adv       = busy && (!out_valid || !out_stall);
  assign last_item = !ok || (chan == LastChan);
  assign load      = q_not_empty && (!busy || (adv && last_item));
  assign q_pop     = load;

  // channels are packed lsb first, so the next one is always at the bottom
  assign raw  = data[RawWidth-1:0];
  assign prod = ProdWidth'(raw) * ProdWidth'(scale_numerator) + ProdWidth'(4);
  assign scaled_value = ValueWidth'(prod[ProdWidth-1:3]) + ValueWidth'(output_offset);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        busy <= 1'b1;
      end else if (adv && last_item) begin
        busy <= 1'b0;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok   <= q_entry.ok;
      cnt  <= q_entry.bad_count;
      data <= q_entry.data;
      chan <= '0;
    end else if (adv) begin
      data <= data >> RawWidth;
      chan <= chan + 1'b1;
    end
    if (adv) begin
      frame_ok      <= ok;
      channel_index <= ok ? chan : '0;
      raw_value     <= ok ? raw : '0;
      channel_value <= ok ? scaled_value : '0;
      bad_frames    <= cnt;
      last_of_frame <= last_item;
    end
  end

  a_last_is_chan15: assert property (@(posedge clk) disable iff (rst)
      out_valid && frame_ok && last_of_frame |-> channel_index == LastChan)
    else $error("good frame ended before channel 15");
  a_bad_status: assert property (@(posedge clk) disable iff (rst)
      out_valid && !frame_ok |-> last_of_frame && raw_value == '0 && channel_value == '0)
    else $error("bad frame status word not cleared");
  a_bad_single: assert property (@(posedge clk) disable iff (rst)
      busy && !ok |-> chan == '0)
    else $error("bad frame produced more than one word");

endmodule

>>> sv/sbus_frame_decoder_unit.sv
`timescale 1ns / 1ps

// SBUS frame decoder. One serial byte is taken per cycle on rx_byte. Every
// 25th byte closes a frame; a frame with header 0x0f and end byte 0x00 gives
// sixteen channel words, one per cycle, each scaled as
// ((raw * scale_numerator + 4) >> 3) + output_offset, and a bad frame gives a
// single status word and bumps a saturating bad-frame count. Frames pass from
// the byte collector to the channel unpacker through a small frame queue
// (QUEUE_DEPTH entries), so input and output stall independently: the input
// stalls only on the closing byte of a frame while that queue is full, and the
// unpacker emits one word per cycle whenever out_stall is low. Configuration
// writes are always ready and apply to the words unpacked afterward.

module sbus_frame_decoder_unit import sbus_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepth
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [ByteWidth-1:0]     rx_byte,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     frame_ok,
  output logic [ChanWidth-1:0]     channel_index,
  output logic [RawWidth-1:0]      raw_value,
  output logic [ValueWidth-1:0]    channel_value,
  output logic [CountWidth-1:0]    bad_frames,
  output logic                     last_of_frame,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CfgIndexWidth-1:0] cfg_index,
  input  logic [CfgDataWidth-1:0]  cfg_data
);

  logic [NumWidth-1:0] scale_numerator;
  logic [OffWidth-1:0] output_offset;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_not_empty;
  frame_t              push_entry;
  frame_t              pop_entry;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_numerator <= NumReset;
      output_offset   <= OffReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegScaleNum:  scale_numerator <= cfg_data[NumWidth-1:0];
        RegOutOffset: output_offset   <= cfg_data[OffWidth-1:0];
        default: ;
      endcase
    end
  end

  sbus_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (push_entry)
  );

  sbus_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .pop_entry  (pop_entry),
    .not_empty  (q_not_empty)
  );

  sbus_back u_back (
    .clk             (clk),
    .rst             (rst),
    .q_not_empty     (q_not_empty),
    .q_entry         (pop_entry),
    .q_pop           (q_pop),
    .scale_numerator (scale_numerator),
    .output_offset   (output_offset),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .frame_ok        (frame_ok),
    .channel_index   (channel_index),
    .raw_value       (raw_value),
    .channel_value   (channel_value),
    .bad_frames      (bad_frames),
    .last_of_frame   (last_of_frame)
  );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sbus_pkg::*;

  typedef struct packed {
    logic                  ok;
    logic [ChanWidth-1:0]  idx;
    logic [RawWidth-1:0]   raw;
    logic [ValueWidth-1:0] value;
    logic [CountWidth-1:0] count;
    logic                  last;
  } chan_word_t;

  typedef enum {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  // index that maps to no register
  localparam logic [CfgIndexWidth-1:0] RegMissing = 8'hff;
  localparam int DrainCycles = 40;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic [ByteWidth-1:0]     rx_byte;
  logic                     out_valid;
  logic                     out_stall;
  logic                     frame_ok;
  logic [ChanWidth-1:0]     channel_index;
  logic [RawWidth-1:0]      raw_value;
  logic [ValueWidth-1:0]    channel_value;
  logic [CountWidth-1:0]    bad_frames;
  logic                     last_of_frame;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  // decoder state mirrored by the testbench
  logic [ByteWidth-1:0]  rx_frame [FrameLen];
  int                    rx_pos;
  logic [CountWidth-1:0] bad_tally;
  logic [NumWidth-1:0]   scale_num;
  logic [OffWidth-1:0]   out_offset;

  chan_word_t pending_words [$];
  int         mismatches;
  int         send_idle_pct;
  int         recv_idle_pct;

  sbus_frame_decoder_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_ok      (frame_ok),
    .channel_index (channel_index),
    .raw_value     (raw_value),
    .channel_value (channel_value),
    .bad_frames    (bad_frames),
    .last_of_frame (last_of_frame),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // collect one byte; on the closing byte of a frame queue up the words it yields
  function automatic void decode_byte(input logic [ByteWidth-1:0] b);
    chan_word_t          w;
    int                  bitpos;
    int                  base;
    int                  v;
    logic [23:0]         span;
    logic [RawWidth-1:0] raw;
    rx_frame[rx_pos] = b;
    rx_pos++;
    if (rx_pos < FrameLen) return;
    rx_pos = 0;
    if (rx_frame[0] != HeaderByte || rx_frame[FrameLen-1] != EndByte) begin
      if (bad_tally != '1) bad_tally++;
      w = '0;
      w.count = bad_tally;
      w.last = 1'b1;
      pending_words.insert(pending_words.size(), w);
      return;
    end
    for (int k = 0; k < NumChannels; k++) begin
      bitpos = k * RawWidth;
      base = 1 + bitpos / 8;
      span = {rx_frame[base+2], rx_frame[base+1], rx_frame[base]};
      raw = RawWidth'(span >> (bitpos % 8));
      v = ((int'(raw) * int'(scale_num) + 4) >> 3) + int'(out_offset);
      w.ok = 1'b1;
      w.idx = ChanWidth'(k);
      w.raw = raw;
      w.value = v[ValueWidth-1:0];
      w.count = bad_tally;
      w.last = (k == NumChannels - 1);
      pending_words.insert(pending_words.size(), w);
    end
  endfunction

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    chan_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: expected no word, got ok %0d channel %0d raw %0d value %0d count %0d",
                 $time, frame_ok, channel_index, raw_value, channel_value, bad_frames);
      end else begin
        want = pending_words.pop_front();
        check_field("frame_ok", want.ok, frame_ok);
        check_field("channel_index", want.idx, channel_index);
        check_field("raw_value", want.raw, raw_value);
        check_field("channel_value", want.value, channel_value);
        check_field("bad_frames", want.count, bad_frames);
        check_field("last_of_frame", want.last, last_of_frame);
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      out_stall = 1'b0;
    end else begin
      out_stall = ($urandom_range(99) < recv_idle_pct);
    end
  end

  // leaves valid high so back-to-back bytes go out without a gap
  task automatic send_byte(input logic [ByteWidth-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    rx_byte = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decode_byte(b);
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [ByteWidth-1:0] hdr, input logic [ByteWidth-1:0] tail,
                            input fill_t fill, input int from = 0,
                            input int upto = FrameLen - 1);
    logic [ByteWidth-1:0] b;
    for (int i = from; i <= upto; i++) begin
      if (i == 0) begin
        b = hdr;
      end else if (i == FrameLen - 1) begin
        b = tail;
      end else begin
        case (fill)
          FILL_ZERO: b = '0;
          FILL_ONES: b = '1;
          default:   b = ByteWidth'($urandom);
        endcase
      end
      send_byte(b);
    end
  endtask

  task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
                           input logic [CfgDataWidth-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      RegScaleNum:  scale_num = data[NumWidth-1:0];
      RegOutOffset: out_offset = data[OffWidth-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drain();
    in_valid = 1'b0;
    while (pending_words.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic test_reset_config();
    send_frame(HeaderByte, EndByte, FILL_ZERO);
    send_frame(HeaderByte, EndByte, FILL_RANDOM);
    wait_drain();
  endtask

  task automatic test_bad_frames();
    send_frame(8'hf0, EndByte, FILL_RANDOM);
    send_frame(HeaderByte, 8'hff, FILL_RANDOM);
    send_frame(8'h00, 8'h0f, FILL_ZERO);
    // a good frame right after keeps the raised count
    send_frame(HeaderByte, EndByte, FILL_RANDOM);
    wait_drain();
  endtask

  task automatic test_config_extremes();
    write_reg(RegScaleNum, '0);
    write_reg(RegOutOffset, '0);
    send_frame(HeaderByte, EndByte, FILL_ONES);
    wait_drain();
    write_reg(RegScaleNum, 12'd15);
    write_reg(RegOutOffset, 12'd4095);
    send_frame(HeaderByte, EndByte, FILL_ONES);
    send_frame(HeaderByte, EndByte, FILL_ZERO);
    wait_drain();
    // upper data bits are dropped, unknown index changes nothing
    write_reg(RegScaleNum, 12'hff7);
    write_reg(RegMissing, 12'h123);
    send_frame(HeaderByte, EndByte, FILL_RANDOM);
    wait_drain();
  endtask

  task automatic test_write_mid_frame();
    send_frame(HeaderByte, EndByte, FILL_RANDOM, 0, 9);
    wait_drain();
    write_reg(RegScaleNum, 12'd3);
    write_reg(RegOutOffset, 12'd1000);
    send_frame(HeaderByte, EndByte, FILL_RANDOM, 10, FrameLen - 1);
    wait_drain();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int frames);
    int                   pick;
    logic [ByteWidth-1:0] hdr;
    logic [ByteWidth-1:0] tail;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    write_reg(RegScaleNum, CfgDataWidth'($urandom));
    write_reg(RegOutOffset, CfgDataWidth'($urandom));
    for (int f = 0; f < frames; f++) begin
      pick = $urandom_range(99);
      hdr = HeaderByte;
      tail = EndByte;
      if (pick >= 75 && pick < 85) begin
        hdr = ByteWidth'($urandom);
        if (hdr == HeaderByte) hdr = ~hdr;
      end else if (pick >= 85 && pick < 93) begin
        tail = ByteWidth'($urandom_range(1, 255));
      end else if (pick >= 93) begin
        hdr = ByteWidth'($urandom);
        tail = ByteWidth'($urandom);
      end
      send_frame(hdr, tail, FILL_RANDOM);
    end
    wait_drain();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    rx_pos = 0;
    bad_tally = '0;
    scale_num = NumReset;
    out_offset = OffReset;
    for (int i = 0; i < FrameLen; i++) rx_frame[i] = '0;
    send_idle_pct = 9;
    recv_idle_pct = 85;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_config();
    test_bad_frames();
    test_config_extremes();
    test_write_mid_frame();
    test_random(9, 85, 1);
    test_random(85, 9, 1);
    test_random(0, 0, 1);

    wait_drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
